// ===== rtl/base64_codec_defines.svh =====
// Assertion macros used by the codec RTL.
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64C_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64c_pkg.sv =====
package b64c_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Symbol value returned for a character outside the alphabet.
    localparam logic [6:0] SYM_INVALID = 7'd64;

    // Most results one transaction can produce, and the depth of the result queue.
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = MAX_RESULTS + 1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       data_present;
        logic       end_of_message;
        logic       stopped;
    } result_t;

    // Maps a 6-bit value to its alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Maps a character to its 6-bit value, or SYM_INVALID.
    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else begin
            v = SYM_INVALID;
        end
        return v;
    endfunction

endpackage

// ===== rtl/base64_codec.sv =====
// Streaming Base64 codec, standard alphabet, direction set by one register.
// Input channel (s_valid/s_ready): one byte or character per transaction, with
// s_last_in marking the final item of a message. Result channel (m_valid/m_ready):
// one character or byte per transaction, with data_present, end_of_message and
// stopped flags. cfg_wr_en writes the direction bit (0 encode, 1 decode) and
// also clears the message state; write it only while the block is idle.
// Each accepted transaction is processed in the cycle it is accepted and its
// results (up to four) are registered into a five-entry result queue, behind
// any results already waiting, and offered on m_valid from its head. The queue
// drains one result per cycle while m_ready is high; s_ready is high while at
// most one result is queued, so the next item is taken while an earlier result
// still waits. Throughput is therefore set by the output port, which takes each
// item's results one at a time (one or two when encoding, four at most at a
// message end). When the receiver stalls, queued results hold and s_ready
// falls once two or more are waiting. Synchronous active-low reset empties the
// queue, sets the direction to encode and clears all message state.
module base64_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_data_present,
    output logic       m_end_of_message,
    output logic       m_stopped
);

`include "base64_codec_defines.svh"

    localparam int QD = b64c_pkg::QUEUE_DEPTH;

    // Message state and the direction register.
    logic        direction_reg;
    logic [11:0] bit_acc_reg, bit_acc_next;
    logic [3:0]  bits_held_reg, bits_held_next;
    logic [1:0]  phase_reg, phase_next;
    logic        halted_reg, halted_next;

    // Result queue; entry 0 is the one offered on the output.
    b64c_pkg::result_t queue_reg [QD];
    b64c_pkg::result_t queue_next [QD];
    logic [2:0]        count_reg, count_next;

    // Results of the transaction being accepted.
    b64c_pkg::result_t res [b64c_pkg::MAX_RESULTS];
    logic [2:0]        res_n;

    logic [19:0] enc_acc;
    logic [3:0]  enc_held, enc_h1, enc_rem;
    logic [11:0] enc_left;
    logic [11:0] dec_acc;
    logic [3:0]  dec_held;
    logic [6:0]  dec_sym;
    logic        push, pop;
    logic [2:0]  base, offs;

    assign s_ready = (count_reg <= 3'd1);
    assign m_valid = (count_reg != 3'd0);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    assign m_out_byte       = queue_reg[0].out_byte;
    assign m_data_present   = queue_reg[0].data_present;
    assign m_end_of_message = queue_reg[0].end_of_message;
    assign m_stopped        = queue_reg[0].stopped;

    // Work for one transaction: results and the next message state.
    always_comb begin
        for (int i = 0; i < b64c_pkg::MAX_RESULTS; i++) begin
            res[i] = '0;
        end
        res_n          = 3'd0;
        bit_acc_next   = bit_acc_reg;
        bits_held_next = bits_held_reg;
        phase_next     = phase_reg;
        halted_next    = halted_reg;
        enc_acc        = {bit_acc_reg, s_data_byte};
        enc_held       = {1'b0, bits_held_reg[2:0]} + 4'd8;
        enc_h1         = enc_held - 4'd6;
        enc_rem        = enc_h1;
        enc_left       = '0;
        dec_acc        = {bit_acc_reg[5:0], 6'd0};
        dec_held       = {1'b0, bits_held_reg[2:0]} + 4'd6;
        dec_sym        = b64c_pkg::sym_value(s_data_byte);

        if (direction_reg == b64c_pkg::DIR_ENCODE) begin
            // The byte always completes at least one character.
            res[0].out_byte     = b64c_pkg::enc_char(6'(enc_acc >> enc_h1));
            res[0].data_present = 1'b1;
            res_n               = 3'd1;
            phase_next          = phase_reg + 2'd1;
            if (enc_h1 >= 4'd6) begin
                enc_rem             = enc_h1 - 4'd6;
                res[1].out_byte     = b64c_pkg::enc_char(6'(enc_acc >> enc_rem));
                res[1].data_present = 1'b1;
                res_n               = 3'd2;
                phase_next          = phase_next + 2'd1;
            end
            enc_left = 12'(enc_acc & ((20'd1 << enc_rem) - 20'd1));
            bit_acc_next   = enc_left;
            bits_held_next = enc_rem;
            if (s_last_in) begin
                // Flush leftover bits, zero-filled on the right, then pad.
                if (enc_rem != 4'd0 && res_n < 3'd4) begin
                    res[res_n[1:0]].out_byte =
                        b64c_pkg::enc_char(6'(enc_left << (4'd6 - enc_rem)));
                    res[res_n[1:0]].data_present = 1'b1;
                    res_n      = res_n + 3'd1;
                    phase_next = phase_next + 2'd1;
                end
                for (int p = 0; p < 3; p++) begin
                    if (phase_next != 2'd0 && res_n < 3'd4) begin
                        res[res_n[1:0]].out_byte     = b64c_pkg::PAD_CHAR;
                        res[res_n[1:0]].data_present = 1'b1;
                        res_n      = res_n + 3'd1;
                        phase_next = phase_next + 2'd1;
                    end
                end
                res[2'(res_n - 3'd1)].end_of_message = 1'b1;
            end
        end else begin
            if (!halted_reg) begin
                if (dec_sym == b64c_pkg::SYM_INVALID) begin
                    halted_next = 1'b1;
                end else begin
                    dec_acc  = {bit_acc_reg[5:0], dec_sym[5:0]};
                    if (dec_held >= 4'd8) begin
                        dec_held            = dec_held - 4'd8;
                        res[0].out_byte     = 8'(dec_acc >> dec_held);
                        res[0].data_present = 1'b1;
                        res_n               = 3'd1;
                    end
                    bit_acc_next   = dec_acc & ((12'd1 << dec_held) - 12'd1);
                    bits_held_next = dec_held;
                end
            end
            if (s_last_in) begin
                // A last character with no byte gives a bare end marker.
                res_n                 = 3'd1;
                res[0].end_of_message = 1'b1;
                res[0].stopped        = halted_next;
            end
        end

        if (s_last_in) begin
            bit_acc_next   = '0;
            bits_held_next = '0;
            phase_next     = '0;
            halted_next    = 1'b0;
        end
    end

    // Queue update: shift out on pop, append new results behind what remains.
    always_comb begin
        base = count_reg - {2'b00, pop};
        offs = '0;
        for (int i = 0; i < QD; i++) begin
            if (pop && i < QD - 1) begin
                queue_next[i] = queue_reg[i + 1];
            end else begin
                queue_next[i] = queue_reg[i];
            end
            offs = 3'(i) - base;
            if (push && 3'(i) >= base && offs < res_n) begin
                queue_next[i] = res[offs[1:0]];
            end
        end
        count_next = base + (push ? res_n : 3'd0);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QD; i++) begin
            queue_reg[i] <= queue_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= b64c_pkg::DIR_ENCODE;
            bit_acc_reg   <= '0;
            bits_held_reg <= '0;
            phase_reg     <= '0;
            halted_reg    <= 1'b0;
            count_reg     <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                // A direction write starts a fresh message.
                direction_reg <= cfg_wr_data;
                bit_acc_reg   <= '0;
                bits_held_reg <= '0;
                phase_reg     <= '0;
                halted_reg    <= 1'b0;
            end else if (push) begin
                bit_acc_reg   <= bit_acc_next;
                bits_held_reg <= bits_held_next;
                phase_reg     <= phase_next;
                halted_reg    <= halted_next;
            end
        end
    end

    `B64C_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= 3'(QD), "result queue overflow")
    `B64C_ASSERT_NOW(a_bits_even, 1'b1, bits_held_reg[0] == 1'b0, "odd bit count held")
    `B64C_ASSERT_NOW(a_dec_phase, direction_reg == b64c_pkg::DIR_DECODE, phase_reg == 2'd0, "group phase moved while decoding")
    `B64C_ASSERT_NEXT(a_msg_clear, push && s_last_in && !cfg_wr_en, bits_held_reg == 4'd0 && phase_reg == 2'd0 && !halted_reg, "message state not cleared after last item")

endmodule
